FILE: hw/rtl/mrgs_pkg.sv
// shared constants and saturating arithmetic helpers for the radial source block
// no dependencies; imported by mrgs_mul, mrgs_div, mhd_radial_geometric_source and the testbench
package mrgs_pkg;

    // configuration register indexes
    localparam logic [3:0] CFG_HEAT_RATIO  = 4'd0;
    localparam logic [3:0] CFG_RADIAL_MODE = 4'd1;

    localparam logic [17:0] GAMMA_RESET = 18'd109227;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // clamp a wide signed value to the 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] res;
        if (x > 64'sh0000_0000_7FFF_FFFF)
        begin
            res = S32_MAX;
        end
        else if (x < -64'sh0000_0000_8000_0000)
        begin
            res = S32_MIN;
        end
        else
        begin
            res = x[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [63:0] sx64(input logic signed [31:0] a);
        return $signed({{32{a[31]}}, a});
    endfunction

    function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat32(sx64(a) + sx64(b));
    endfunction

    function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat32(sx64(a) - sx64(b));
    endfunction

    function automatic logic signed [31:0] sneg(input logic signed [31:0] a);
        return sat32(-sx64(a));
    endfunction

    function automatic logic signed [31:0] sdbl(input logic signed [31:0] a);
        return sat32(sx64(a) + sx64(a));
    endfunction

endpackage

FILE: hw/rtl/mrgs_mul.sv
// fixed-point multiplier: registered 32x32 product, then combinational round half up
// and saturate to 32 bits; depends on mrgs_pkg
module mrgs_mul
    import mrgs_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] p
);

    localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;
    logic signed [63:0] rnd;

    // product register
    assign prod_next = a * b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    // round half up, floor shift, saturate
    assign rnd = (prod_reg + RND) >>> FRAC_BITS;
    assign p   = sat32(rnd);

endmodule

FILE: hw/rtl/mrgs_div.sv
// pipelined restoring divider for (num * 2^FRAC_BITS) / den, one quotient bit per
// stage, truncated toward zero and saturated; depends on mrgs_pkg
module mrgs_div
    import mrgs_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic signed [31:0] quo
);

    localparam int NB = 32 + FRAC_BITS;

    logic [31:0]    rem_reg [NB+1];
    logic [NB-1:0]  nq_reg  [NB+1];
    logic [31:0]    den_reg [NB+1];
    logic           neg_reg [NB+1];

    logic [31:0]    rem_next [NB+1];
    logic [NB-1:0]  nq_next  [NB+1];

    logic [31:0]    num_mag;
    logic [31:0]    den_mag;
    logic [NB-1:0]  q;
    logic           big;

    // magnitudes and result sign
    assign num_mag = num[31] ? (~num + 32'd1) : num;
    assign den_mag = den[31] ? (~den + 32'd1) : den;

    always_comb
    begin
        logic [32:0] trial;
        logic        ge;
        rem_next[0] = '0;
        nq_next[0]  = {num_mag, {FRAC_BITS{1'b0}}};
        for (int i = 1; i <= NB; i++)
        begin
            trial       = {rem_reg[i-1], nq_reg[i-1][NB-1]};
            ge          = (trial >= {1'b0, den_reg[i-1]});
            rem_next[i] = ge ? 32'(trial - {1'b0, den_reg[i-1]}) : trial[31:0];
            nq_next[i]  = {nq_reg[i-1][NB-2:0], ge};
        end
    end

    // one quotient bit per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem_next[0];
            nq_reg[0]  <= nq_next[0];
            den_reg[0] <= den_mag;
            neg_reg[0] <= num[31] ^ den[31];
            for (int i = 1; i <= NB; i++)
            begin
                rem_reg[i] <= rem_next[i];
                nq_reg[i]  <= nq_next[i];
                den_reg[i] <= den_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    // apply sign and saturate
    assign q   = nq_reg[NB];
    assign big = |q[NB-1:31];

    always_comb
    begin
        if (big)
        begin
            quo = neg_reg[NB] ? S32_MIN : S32_MAX;
        end
        else if (neg_reg[NB])
        begin
            quo = -$signed(q[31:0]);
        end
        else
        begin
            quo = $signed(q[31:0]);
        end
    end

endmodule

FILE: hw/rtl/mhd_radial_geometric_source.sv
// signed fixed-point datapath, Q16.16 at the default FRAC_BITS
// throughput: one cell per cycle unless the output stalls; the depth is set by the two chained bit-per-stage
// dividers (by density, then by radius) of 34 + FRAC_BITS stages each
// a stalled output holds the whole pipeline; reset clears all valid bits and loads
// the heat ratio with 5/3 and radial_mode with 1
// top level; depends on mrgs_pkg, mrgs_mul, mrgs_div
module mhd_radial_geometric_source
    import mrgs_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] radius,
    input  logic signed [31:0] density,
    input  logic signed [31:0] mom_radial,
    input  logic signed [31:0] mom_azimuthal,
    input  logic signed [31:0] mom_axial,
    input  logic signed [31:0] energy,
    input  logic signed [31:0] field_radial,
    input  logic signed [31:0] field_azimuthal,
    input  logic signed [31:0] field_axial,
    input  logic               last_cell,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] src_mass,
    output logic signed [31:0] src_mom_radial,
    output logic signed [31:0] src_mom_azimuthal,
    output logic signed [31:0] src_mom_axial,
    output logic signed [31:0] src_energy,
    output logic signed [31:0] src_field_azimuthal,
    output logic               div_error,
    output logic               last_out
);

    localparam int LD    = 34 + FRAC_BITS;   // stage span from each divider's operand stage to its result stage
    localparam int S_SQ  = 2;
    localparam int S_A1  = 3;
    localparam int S_A2  = 4;
    localparam int S_HB  = S_A2 + 2;
    localparam int S_T   = S_A2 + LD;
    localparam int S_RU  = S_T + 2;
    localparam int S_E1  = S_T + 3;
    localparam int S_RX  = S_T + 4;
    localparam int S_X   = S_T + 5;
    localparam int S_PG  = S_T + 6;
    localparam int S_PT  = S_T + 7;
    localparam int S_SM  = S_T + 8;
    localparam int S_UE  = S_T + 10;
    localparam int S_Q   = S_UE + LD;
    localparam int NSTG  = S_Q + 1;

    localparam logic signed [31:0] HALF  = 32'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;

    typedef struct packed {
        logic signed [31:0] r;
        logic signed [31:0] rho;
        logic signed [31:0] mr;
        logic signed [31:0] mp;
        logic signed [31:0] mz;
        logic signed [31:0] en;
        logic signed [31:0] br;
        logic signed [31:0] bp;
        logic signed [31:0] bz;
        logic signed [31:0] mr2;
        logic signed [31:0] mp2;
        logic signed [31:0] mz2;
        logic signed [31:0] br2;
        logic signed [31:0] bp2;
        logic signed [31:0] bz2;
        logic signed [31:0] m2a;
        logic signed [31:0] b2a;
        logic signed [31:0] m2;
        logic signed [31:0] b2;
        logic signed [31:0] hb2;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] w;
        logic signed [31:0] ke2;
        logic signed [31:0] ru;
        logic signed [31:0] hk;
        logic signed [31:0] ub;
        logic signed [31:0] e1;
        logic signed [31:0] ruu;
        logic signed [31:0] ruv;
        logic signed [31:0] ruw;
        logic signed [31:0] e2;
        logic signed [31:0] x1;
        logic signed [31:0] x2;
        logic signed [31:0] pg;
        logic signed [31:0] pt;
        logic signed [31:0] sm;
        logic signed [31:0] ue;
        logic signed [31:0] q0;
        logic signed [31:0] q1;
        logic signed [31:0] q2;
        logic signed [31:0] q3;
        logic signed [31:0] q4;
        logic signed [31:0] q5;
        logic               err;
        logic               mode;
        logic               last;
    } ctx_t;

    logic [17:0]        heat_ratio_reg;
    logic               radial_mode_reg;
    logic signed [31:0] gm1;

    ctx_t               ctx_reg  [NSTG];
    ctx_t               ctx_next [NSTG];
    logic               vld_reg  [NSTG];
    logic               adv;

    logic               out_valid_reg;
    logic signed [31:0] src_mass_reg;
    logic signed [31:0] src_mom_radial_reg;
    logic signed [31:0] src_mom_azimuthal_reg;
    logic signed [31:0] src_mom_axial_reg;
    logic signed [31:0] src_energy_reg;
    logic signed [31:0] src_field_azimuthal_reg;
    logic               div_error_reg;
    logic               last_out_reg;

    logic signed [31:0] sq_in  [6];
    logic signed [31:0] sq_out [6];
    logic signed [31:0] dv_num [4];
    logic signed [31:0] dv_out [4];
    logic signed [31:0] rd_num [6];
    logic signed [31:0] rd_out [6];
    logic signed [31:0] m_hb2, m_ru, m_hk, m_ub, m_ruu, m_ruv, m_ruw, m_pg, m_ue;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_ratio_reg  <= GAMMA_RESET;
            radial_mode_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HEAT_RATIO:  heat_ratio_reg  <= cfg_data[17:0];
                CFG_RADIAL_MODE: radial_mode_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign gm1 = sat32($signed({46'b0, heat_ratio_reg}) - ONE64);

    // whole pipeline moves when the output register can take a transfer
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // squares of momenta and field
    assign sq_in[0] = ctx_reg[0].mr;
    assign sq_in[1] = ctx_reg[0].mp;
    assign sq_in[2] = ctx_reg[0].mz;
    assign sq_in[3] = ctx_reg[0].br;
    assign sq_in[4] = ctx_reg[0].bp;
    assign sq_in[5] = ctx_reg[0].bz;

    for (genvar g = 0; g < 6; g++)
    begin : g_sq
        mrgs_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
            .clk(clk), .en(adv), .a(sq_in[g]), .b(sq_in[g]), .p(sq_out[g])
        );
    end

    // divisions by density
    assign dv_num[0] = ctx_reg[S_A2].mr;
    assign dv_num[1] = ctx_reg[S_A2].mp;
    assign dv_num[2] = ctx_reg[S_A2].mz;
    assign dv_num[3] = ctx_reg[S_A2].m2;

    for (genvar g = 0; g < 4; g++)
    begin : g_dv
        mrgs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .clk(clk), .en(adv), .num(dv_num[g]), .den(ctx_reg[S_A2].rho),
            .quo(dv_out[g])
        );
    end

    // products: half of b2 alongside the density division, the rest after it
    mrgs_mul #(.FRAC_BITS(FRAC_BITS)) u_hb2 (
        .clk(clk), .en(adv), .a(HALF), .b(ctx_reg[S_A2].b2), .p(m_hb2)
    );
    mrgs_mul #(.FRAC_BITS(FRAC_BITS)) u_ru (
        .clk(clk), .en(adv), .a(ctx_reg[S_T].rho), .b(ctx_reg[S_T].u), .p(m_ru)
    );
    mrgs_mul #(.FRAC_BITS(FRAC_BITS)) u_hk (
        .clk(clk), .en(adv), .a(HALF), .b(ctx_reg[S_T].ke2), .p(m_hk)
    );
    mrgs_mul #(.FRAC_BITS(FRAC_BITS)) u_ub (
        .clk(clk), .en(adv), .a(ctx_reg[S_T].u), .b(ctx_reg[S_T].bp), .p(m_ub)
    );
    mrgs_mul #(.FRAC_BITS(FRAC_BITS)) u_ruu (
        .clk(clk), .en(adv), .a(ctx_reg[S_RU].ru), .b(ctx_reg[S_RU].u), .p(m_ruu)
    );
    mrgs_mul #(.FRAC_BITS(FRAC_BITS)) u_ruv (
        .clk(clk), .en(adv), .a(ctx_reg[S_RU].ru), .b(ctx_reg[S_RU].v), .p(m_ruv)
    );
    mrgs_mul #(.FRAC_BITS(FRAC_BITS)) u_ruw (
        .clk(clk), .en(adv), .a(ctx_reg[S_RU].ru), .b(ctx_reg[S_RU].w), .p(m_ruw)
    );
    mrgs_mul #(.FRAC_BITS(FRAC_BITS)) u_pg (
        .clk(clk), .en(adv), .a(gm1), .b(ctx_reg[S_RX].e2), .p(m_pg)
    );
    mrgs_mul #(.FRAC_BITS(FRAC_BITS)) u_ue (
        .clk(clk), .en(adv), .a(ctx_reg[S_SM].u), .b(ctx_reg[S_SM].sm), .p(m_ue)
    );

    // divisions by radius
    assign rd_num[0] = ctx_reg[S_UE].ru;
    assign rd_num[1] = ctx_reg[S_UE].x1;
    assign rd_num[2] = ctx_reg[S_UE].x2;
    assign rd_num[3] = ctx_reg[S_UE].ruw;
    assign rd_num[4] = ctx_reg[S_UE].ue;
    assign rd_num[5] = ctx_reg[S_UE].ub;

    for (genvar g = 0; g < 6; g++)
    begin : g_rd
        mrgs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .clk(clk), .en(adv), .num(rd_num[g]), .den(ctx_reg[S_UE].r),
            .quo(rd_out[g])
        );
    end

    // stage contents: carry forward, then overwrite what each stage computes
    always_comb
    begin
        ctx_next[0]      = ctx_reg[0];
        ctx_next[0].r    = radius;
        ctx_next[0].rho  = density;
        ctx_next[0].mr   = mom_radial;
        ctx_next[0].mp   = mom_azimuthal;
        ctx_next[0].mz   = mom_axial;
        ctx_next[0].en   = energy;
        ctx_next[0].br   = field_radial;
        ctx_next[0].bp   = field_azimuthal;
        ctx_next[0].bz   = field_axial;
        ctx_next[0].mode = radial_mode_reg;
        ctx_next[0].err  = radial_mode_reg && (density == '0 || radius == '0);
        ctx_next[0].last = last_cell;

        for (int k = 1; k < NSTG; k++)
        begin
            ctx_next[k] = ctx_reg[k-1];
        end

        ctx_next[S_SQ].mr2 = sq_out[0];
        ctx_next[S_SQ].mp2 = sq_out[1];
        ctx_next[S_SQ].mz2 = sq_out[2];
        ctx_next[S_SQ].br2 = sq_out[3];
        ctx_next[S_SQ].bp2 = sq_out[4];
        ctx_next[S_SQ].bz2 = sq_out[5];

        ctx_next[S_A1].m2a = sadd(ctx_reg[S_A1-1].mr2, ctx_reg[S_A1-1].mp2);
        ctx_next[S_A1].b2a = sadd(ctx_reg[S_A1-1].br2, ctx_reg[S_A1-1].bp2);
        ctx_next[S_A2].m2  = sadd(ctx_reg[S_A2-1].m2a, ctx_reg[S_A2-1].mz2);
        ctx_next[S_A2].b2  = sadd(ctx_reg[S_A2-1].b2a, ctx_reg[S_A2-1].bz2);

        ctx_next[S_HB].hb2 = m_hb2;

        ctx_next[S_T].u    = dv_out[0];
        ctx_next[S_T].v    = dv_out[1];
        ctx_next[S_T].w    = dv_out[2];
        ctx_next[S_T].ke2  = dv_out[3];

        ctx_next[S_RU].ru  = m_ru;
        ctx_next[S_RU].hk  = m_hk;
        ctx_next[S_RU].ub  = m_ub;

        ctx_next[S_E1].e1  = ssub(ctx_reg[S_E1-1].en, ctx_reg[S_E1-1].hk);

        ctx_next[S_RX].ruu = m_ruu;
        ctx_next[S_RX].ruv = m_ruv;
        ctx_next[S_RX].ruw = m_ruw;
        ctx_next[S_RX].e2  = ssub(ctx_reg[S_RX-1].e1, ctx_reg[S_RX-1].hb2);

        ctx_next[S_X].x1   = sadd(ctx_reg[S_X-1].ruu, ctx_reg[S_X-1].bp2);
        ctx_next[S_X].x2   = sdbl(ctx_reg[S_X-1].ruv);

        ctx_next[S_PG].pg  = m_pg;
        ctx_next[S_PT].pt  = sadd(ctx_reg[S_PT-1].pg, ctx_reg[S_PT-1].hb2);
        ctx_next[S_SM].sm  = sadd(ctx_reg[S_SM-1].en, ctx_reg[S_SM-1].pt);
        ctx_next[S_UE].ue  = m_ue;

        ctx_next[S_Q].q0   = rd_out[0];
        ctx_next[S_Q].q1   = rd_out[1];
        ctx_next[S_Q].q2   = rd_out[2];
        ctx_next[S_Q].q3   = rd_out[3];
        ctx_next[S_Q].q4   = rd_out[4];
        ctx_next[S_Q].q5   = rd_out[5];
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                ctx_reg[k] <= ctx_next[k];
            end
        end
    end

    // valid bits travel with the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < NSTG; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // output register: negate, zero on error or non-radial mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_reg[S_Q];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (!ctx_reg[S_Q].mode || ctx_reg[S_Q].err)
            begin
                src_mass_reg            <= '0;
                src_mom_radial_reg      <= '0;
                src_mom_azimuthal_reg   <= '0;
                src_mom_axial_reg       <= '0;
                src_energy_reg          <= '0;
                src_field_azimuthal_reg <= '0;
            end
            else
            begin
                src_mass_reg            <= sneg(ctx_reg[S_Q].q0);
                src_mom_radial_reg      <= sneg(ctx_reg[S_Q].q1);
                src_mom_azimuthal_reg   <= sneg(ctx_reg[S_Q].q2);
                src_mom_axial_reg       <= sneg(ctx_reg[S_Q].q3);
                src_energy_reg          <= sneg(ctx_reg[S_Q].q4);
                src_field_azimuthal_reg <= sneg(ctx_reg[S_Q].q5);
            end
            div_error_reg <= ctx_reg[S_Q].err;
            last_out_reg  <= ctx_reg[S_Q].last;
        end
    end

    assign out_valid           = out_valid_reg;
    assign src_mass            = src_mass_reg;
    assign src_mom_radial      = src_mom_radial_reg;
    assign src_mom_azimuthal   = src_mom_azimuthal_reg;
    assign src_mom_axial       = src_mom_axial_reg;
    assign src_energy          = src_energy_reg;
    assign src_field_azimuthal = src_field_azimuthal_reg;
    assign div_error           = div_error_reg;
    assign last_out            = last_out_reg;

    // an error result carries zero mass, radial momentum, energy and azimuthal field
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_error |-> src_mass == '0 && src_mom_radial == '0 &&
            src_energy == '0 && src_field_azimuthal == '0)
        else $error("error result with nonzero sources");

    // non-radial mode gives zero mass and azimuthal momentum and no error flag
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[S_Q] && !ctx_reg[S_Q].mode |=>
            out_valid && !div_error && src_mass == '0 && src_mom_azimuthal == '0)
        else $error("non-radial result not zeroed");

    // an occupied first stage moves on to the second when the pipeline advances
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[0] |=> vld_reg[1])
        else $error("item lost between first stages");

endmodule

FILE: tb/mhd_radial_geometric_source_tb.sv
// self-checking testbench for the cylindrical mhd geometric source block
// depends on mrgs_pkg (register indexes, gamma reset) and mhd_radial_geometric_source
module mhd_radial_geometric_source_tb
    import mrgs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam int LATENCY = 83 + 2 * FB;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [31:0] q_t;

    typedef struct packed {
        q_t   r;
        q_t   rho;
        q_t   mr;
        q_t   mp;
        q_t   mz;
        q_t   en;
        q_t   br;
        q_t   bp;
        q_t   bz;
        logic last;
    } cell_t;

    typedef struct packed {
        q_t   mass;
        q_t   mom_r;
        q_t   mom_p;
        q_t   mom_z;
        q_t   en;
        q_t   bphi;
        logic err;
        logic last;
    } source_t;

    // one directed row: stimulus, and an optional typed-in expectation
    typedef struct packed {
        cell_t   stim;
        logic    fixed;
        source_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [3:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    cell_t cur = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    source_t got;

    mhd_radial_geometric_source #(.FRAC_BITS(FB)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .radius(cur.r), .density(cur.rho), .mom_radial(cur.mr),
        .mom_azimuthal(cur.mp), .mom_axial(cur.mz), .energy(cur.en),
        .field_radial(cur.br), .field_azimuthal(cur.bp), .field_axial(cur.bz),
        .last_cell(cur.last),
        .out_valid(out_valid), .out_ready(out_ready),
        .src_mass(got.mass), .src_mom_radial(got.mom_r),
        .src_mom_azimuthal(got.mom_p), .src_mom_axial(got.mom_z),
        .src_energy(got.en), .src_field_azimuthal(got.bphi),
        .div_error(got.err), .last_out(got.last)
    );

    always #10 clk = ~clk;

    // predictor copy of the registers
    logic [17:0] gamma_q = GAMMA_RESET;
    logic        radial_on = 1'b1;

    source_t pending_sources[$];
    int mismatches = 0;
    int received = 0;
    int cycles = 0;
    logic stall_off = 1'b0;
    logic hold_long = 1'b0;

    function automatic q_t clamp(input longint x);
        if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return q_t'(x);
    endfunction

    // round half up: floor of (a*b + half) / 2^fb
    function automatic q_t qmul(input q_t a, input q_t b);
        longint p;
        p = longint'(a) * longint'(b) + (64'sd1 <<< (FB - 1));
        return clamp(p >>> FB);
    endfunction

    // truncating divide toward zero
    function automatic q_t qdiv(input q_t a, input q_t b);
        longint n;
        n = longint'(a) * (64'sd1 <<< FB);
        return clamp(n / longint'(b));
    endfunction

    function automatic q_t qadd(input q_t a, input q_t b);
        return clamp(longint'(a) + longint'(b));
    endfunction

    function automatic q_t qsub(input q_t a, input q_t b);
        return clamp(longint'(a) - longint'(b));
    endfunction

    function automatic source_t geometric_sources(input cell_t c);
        source_t s;
        q_t half, u, v, w, m2, ke2, bp2, b2, hb2, gm1, pg, pt, ru;
        s = '0;
        s.last = c.last;
        half = q_t'(1 <<< (FB - 1));
        if (radial_on)
        begin
            if (c.rho == 0 || c.r == 0)
            begin
                s.err = 1'b1;
            end
            else
            begin
                u = qdiv(c.mr, c.rho);
                v = qdiv(c.mp, c.rho);
                w = qdiv(c.mz, c.rho);
                m2 = qadd(qadd(qmul(c.mr, c.mr), qmul(c.mp, c.mp)), qmul(c.mz, c.mz));
                ke2 = qdiv(m2, c.rho);
                bp2 = qmul(c.bp, c.bp);
                b2 = qadd(qadd(qmul(c.br, c.br), bp2), qmul(c.bz, c.bz));
                hb2 = qmul(half, b2);
                gm1 = clamp(longint'(gamma_q) - (64'sd1 <<< FB));
                pg = qmul(gm1, qsub(qsub(c.en, qmul(half, ke2)), hb2));
                pt = qadd(pg, hb2);
                ru = qmul(c.rho, u);
                s.mass = qsub(0, qdiv(ru, c.r));
                s.mom_r = qsub(0, qdiv(qadd(qmul(ru, u), bp2), c.r));
                s.mom_p = qsub(0, qdiv(qadd(qmul(ru, v), qmul(ru, v)), c.r));
                s.mom_z = qsub(0, qdiv(qmul(ru, w), c.r));
                s.en = qsub(0, qdiv(qmul(u, qadd(c.en, pt)), c.r));
                s.bphi = qsub(0, qdiv(qmul(u, c.bp), c.r));
            end
        end
        return s;
    endfunction

    function automatic q_t any_q();
        case ($urandom_range(0, 5))
            0: return q_t'($urandom);
            1: return 32'sh7FFFFFFF;
            2: return 32'sh80000000;
            default: return q_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh4_0000);
        endcase
    endfunction

    // plausible cell: positive density, radius near unity (negative in one of ten), moderate values
    function automatic cell_t physical_cell();
        cell_t c;
        c.r   = q_t'($urandom_range(32'h0000_1000, 32'h0010_0000));
        c.rho = q_t'($urandom_range(32'h0000_2000, 32'h0008_0000));
        c.mr  = q_t'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh2_0000);
        c.mp  = q_t'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh2_0000);
        c.mz  = q_t'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh2_0000);
        c.en  = q_t'($urandom_range(0, 32'h0040_0000));
        c.br  = q_t'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh1_0000);
        c.bp  = q_t'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh1_0000);
        c.bz  = q_t'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh1_0000);
        if ($urandom_range(0, 9) == 0) c.r = -c.r;
        c.last = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic cell_t random_cell();
        cell_t c;
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) return physical_cell();
        c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, 1'($urandom)};
        if (k == 8)
        begin
            c.r = any_q(); c.rho = any_q(); c.mr = any_q(); c.bp = any_q();
        end
        if (k == 9)
        begin
            if ($urandom_range(0, 1)) c.rho = 0; else c.r = 0;
        end
        return c;
    endfunction

    // compare one result against the oldest expectation
    task automatic check_source(input source_t exp_s);
        if (got !== exp_s)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch at result %0d: exp %h %h %h %h %h %h e%b l%b",
                         received, exp_s.mass, exp_s.mom_r, exp_s.mom_p, exp_s.mom_z,
                         exp_s.en, exp_s.bphi, exp_s.err, exp_s.last);
                $display("                     got %h %h %h %h %h %h e%b l%b",
                         got.mass, got.mom_r, got.mom_p, got.mom_z,
                         got.en, got.bphi, got.err, got.last);
            end
        end
    endtask

    // output side: random stalls, a long hold-off on request
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (out_valid && out_ready)
            begin
                if (pending_sources.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %0d", received);
                end
                else
                begin
                    check_source(pending_sources.pop_front());
                end
                received++;
            end
            if (hold_long)
            begin
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else if (!stall_off && $urandom_range(0, 5) == 0)
            begin
                stall_left <= $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off, counted here
    task automatic hold_output(input int n);
        hold_long = 1'b1;
        repeat (n) @(posedge clk);
        hold_long = 1'b0;
    endtask

    task automatic send_cell(input cell_t c);
        if (!stall_off && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cur <= c;
        do @(posedge clk); while (!in_ready);
        pending_sources.push_back(geometric_sources(c));
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_HEAT_RATIO) gamma_q = val[17:0];
        else if (idx == CFG_RADIAL_MODE) radial_on = val[0];
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_sources.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // timeout watchdog
    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycles);
        $display("DONE: errors detected");
        $finish;
    end

    row_t rows[$];
    row_t rw;
    cell_t base;
    int phase;

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: zero density, zero radius, extremes, plausible cells
        base = '0;
        rw = '0; rw.stim = base; rw.stim.r = 32'sh10000; rw.fixed = 1'b1;
        rw.want.err = 1'b1; rows.push_back(rw);
        rw = '0; rw.stim = base; rw.stim.rho = 32'sh10000; rw.stim.last = 1'b1;
        rw.fixed = 1'b1; rw.want.err = 1'b1; rw.want.last = 1'b1; rows.push_back(rw);
        rw = '0; rw.stim = '1; rw.stim.r = 0; rw.fixed = 1'b1;
        rw.want.err = 1'b1; rw.want.last = 1'b1; rows.push_back(rw);
        rw = '0;
        rw.stim = {{9{32'sh7FFFFFFF}}, 1'b0}; rows.push_back(rw);
        rw.stim = {{9{32'sh80000000}}, 1'b1}; rows.push_back(rw);
        rw.stim = {32'sh80000000, 32'sh00000001, {7{32'sh7FFFFFFF}}, 1'b0};
        rows.push_back(rw);
        rw.stim = {32'sh00000001, 32'sh00000001, {7{32'sh80000000}}, 1'b1};
        rows.push_back(rw);
        rw.stim = {32'shFFFFFFFF, 32'shFFFFFFFF, {7{32'sh00010000}}, 1'b0};
        rows.push_back(rw);
        // unit cell at unit radius
        rw.stim = {32'sh10000, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh8000,
                   32'sh40000, 32'sh10000, 32'sh8000, 32'sh4000, 1'b1};
        rows.push_back(rw);
        for (int i = 0; i < 8; i++)
        begin
            rw.stim = physical_cell();
            rows.push_back(rw);
        end

        foreach (rows[i])
        begin
            send_cell(rows[i].stim);
            if (rows[i].fixed)
                pending_sources[pending_sources.size() - 1] = rows[i].want;
        end
        drain();

        // register phases: extremes of gamma, non-radial mode, out-of-range index
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_HEAT_RATIO, 32'd65536);
                end
                1:
                begin
                    write_reg(CFG_HEAT_RATIO, 32'd196608);
                end
                2:
                begin
                    write_reg(CFG_RADIAL_MODE, 32'd0);
                end
                3:
                begin
                    write_reg(CFG_RADIAL_MODE, 32'hFFFF_FFFF);
                    write_reg(CFG_HEAT_RATIO, $urandom);
                end
                4:
                begin
                    write_reg(4'd7, $urandom);
                    write_reg(CFG_HEAT_RATIO, 32'd98304);
                end
                default:
                begin
                    write_reg(CFG_HEAT_RATIO, 32'd109227);
                    write_reg(CFG_RADIAL_MODE, 32'd1);
                end
            endcase
            if (phase == 2)
            begin
                // four cells in non-radial mode, zero then random, all zero with no error
                for (int i = 0; i < 4; i++)
                begin
                    rw = '0;
                    rw.stim = (i == 0) ? cell_t'('0) : random_cell();
                    send_cell(rw.stim);
                end
            end
            if (phase == 1)
            begin
                fork
                    hold_output(LATENCY * 3);
                    for (int i = 0; i < 250; i++) send_cell(random_cell());
                join
            end
            else
            begin
                if (phase == 5) stall_off = 1'b1;
                for (int i = 0; i < 90; i++) send_cell(random_cell());
            end
            drain();
        end

        $display("covered %0d cells over %0d register settings, incl. zero-divide,",
                 received, 7);
        $display("saturation, non-radial mode and a long output hold-off");
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/mrgs_pkg.sv
hw/rtl/mrgs_mul.sv
hw/rtl/mrgs_div.sv
hw/rtl/mhd_radial_geometric_source.sv
tb/mhd_radial_geometric_source_tb.sv
